@@ hw/rtl/tlc_pkg.sv @@
`timescale 1ns / 1ps

package tlc_pkg;

  // Default geometry of the two cache levels.
  localparam int L1_SETS_DEF    = 256;
  localparam int L1_WAYS_DEF    = 8;
  localparam int L2_SETS_DEF    = 1024;
  localparam int L2_WAYS_DEF    = 16;
  localparam int ADDR_WIDTH_DEF = 32;

  // Width of the address field on the input channel.
  localparam int IN_ADDR_W = 32;

  // Configuration port layout.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 5;

  // Depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLOCK_OFFSET = 3'd0,
    CFG_L1_INDEX     = 3'd1,
    CFG_L1_WAYS      = 3'd2,
    CFG_L2_ENABLE    = 3'd3,
    CFG_L2_INDEX     = 3'd4,
    CFG_L2_WAYS      = 3'd5
  } cfg_reg_t;

  // Register values after reset.
  localparam logic [2:0] RST_BLOCK_OFFSET = 3'd5;
  localparam logic [3:0] RST_L1_INDEX     = 4'd5;
  localparam logic [3:0] RST_L1_WAYS      = 4'd4;
  localparam logic       RST_L2_ENABLE    = 1'b1;
  localparam logic [3:0] RST_L2_INDEX     = 4'd9;
  localparam logic [4:0] RST_L2_WAYS      = 5'd8;

  typedef struct packed {
    logic [2:0] block_offset_bits;
    logic [3:0] l1_index_bits;
    logic [3:0] l1_ways;
    logic       l2_enable;
    logic [3:0] l2_index_bits;
    logic [4:0] l2_ways;
  } cfg_t;

  // Outcome of one access to a cache level.
  typedef struct packed {
    logic hit;
    logic victim_dirty;
  } lv_res_t;

  // One result transaction.
  typedef struct packed {
    logic       l1_hit;
    logic       l1_writeback;
    logic       l2_read_issued;
    logic       l2_read_hit;
    logic       l2_write_issued;
    logic       l2_write_hit;
    logic [1:0] l2_writebacks;
    logic [2:0] mem_transfers;
  } result_t;

  typedef enum logic [1:0] {
    LV_CLEAR,
    LV_IDLE,
    LV_EVAL,
    LV_WRITE
  } lv_state_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_L1,
    BK_L2W,
    BK_L2R,
    BK_DONE
  } bk_state_t;

endpackage

@@ hw/rtl/tlc_if.sv @@
`timescale 1ns / 1ps

// Input channel: one access per transaction.
interface tlc_in_if;
  logic                         valid;
  logic                         ready;
  logic                         func;
  logic [tlc_pkg::IN_ADDR_W-1:0] address;

  modport source (output valid, output func, output address, input ready);
  modport sink   (input valid, input func, input address, output ready);
endinterface

// Result channel: one result per access.
interface tlc_out_if;
  logic       valid;
  logic       ready;
  logic       l1_hit;
  logic       l1_writeback;
  logic       l2_read_issued;
  logic       l2_read_hit;
  logic       l2_write_issued;
  logic       l2_write_hit;
  logic [1:0] l2_writebacks;
  logic [2:0] mem_transfers;

  modport source (output valid, output l1_hit, output l1_writeback, output l2_read_issued,
                  output l2_read_hit, output l2_write_issued, output l2_write_hit,
                  output l2_writebacks, output mem_transfers, input ready);
  modport sink   (input valid, input l1_hit, input l1_writeback, input l2_read_issued,
                  input l2_read_hit, input l2_write_issued, input l2_write_hit,
                  input l2_writebacks, input mem_transfers, output ready);
endinterface

// Configuration write channel.
interface tlc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [tlc_pkg::CFG_IDX_W-1:0]  index;
  logic [tlc_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/tlc_front.sv @@
`timescale 1ns / 1ps

module tlc_front #(
  parameter int ADDR_WIDTH = tlc_pkg::ADDR_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  tlc_in_if.sink                in_ch,
  input  logic                  init_done,
  input  logic                  pop,
  output logic                  head_valid,
  output logic                  head_func,
  output logic [ADDR_WIDTH-1:0] head_addr
);

  localparam int PW = (tlc_pkg::QUEUE_DEPTH > 1) ? $clog2(tlc_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(tlc_pkg::QUEUE_DEPTH + 1);

  logic                  q_func_r [tlc_pkg::QUEUE_DEPTH];
  logic [ADDR_WIDTH-1:0] q_addr_r [tlc_pkg::QUEUE_DEPTH];
  logic [PW-1:0]         wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]         rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic                  push;
  logic [63:0]           addr_ext;

  // Accept only after the clearing pass and while the queue has room.
  assign in_ch.ready = init_done && (count_r < CW'(tlc_pkg::QUEUE_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;

  // The address is zero-extended or cut to the ADDR_WIDTH parameter.
  assign addr_ext = 64'(in_ch.address);

  assign head_valid = (count_r != '0);
  assign head_func  = q_func_r[rd_ptr_r];
  assign head_addr  = q_addr_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(tlc_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(tlc_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue entries carry no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      q_func_r[wr_ptr_r] <= in_ch.func;
      q_addr_r[wr_ptr_r] <= addr_ext[ADDR_WIDTH-1:0];
    end
  end

endmodule

@@ hw/rtl/tlc_level.sv @@
`timescale 1ns / 1ps

module tlc_level #(
  parameter int SETS       = tlc_pkg::L1_SETS_DEF,
  parameter int WAYS       = tlc_pkg::L1_WAYS_DEF,
  parameter int ADDR_WIDTH = tlc_pkg::ADDR_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [2:0]              block_offset_bits,
  input  logic [3:0]              index_bits_req,
  input  logic [4:0]              ways_req,
  input  logic                    req,
  input  logic                    req_write,
  input  logic [ADDR_WIDTH-1:0]   req_addr,
  output logic                    ready,
  output logic                    done,
  output tlc_pkg::lv_res_t        res,
  output logic [ADDR_WIDTH-1:0]   victim_addr
);

  localparam int AW    = ADDR_WIDTH;
  localparam int SW    = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WIX   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int IBMAX = $clog2(SETS + 1) - 1;

  // Set memory, one row per set, all fields written together.
  logic [WAYS-1:0]           mem_v  [SETS];
  logic [WAYS-1:0]           mem_d  [SETS];
  logic [WAYS-1:0][WIX-1:0]  mem_rk [SETS];
  logic [WAYS-1:0][AW-1:0]   mem_tg [SETS];

  tlc_pkg::lv_state_t        state_r, state_nxt;
  logic [SW-1:0]             clr_r;
  logic [SW-1:0]             set_r;
  logic [AW-1:0]             tag_r;
  logic                      wr_r;
  logic [WAYS-1:0]           rd_v_r, rd_d_r;
  logic [WAYS-1:0][WIX-1:0]  rd_rk_r;
  logic [WAYS-1:0][AW-1:0]   rd_tg_r;
  logic                      hit_r, vd_r;
  logic [WIX-1:0]            x_r;
  logic [AW-1:0]             vaddr_r;

  logic [3:0]                ib;
  logic [5:0]                ways_eff;
  logic [4:0]                sh;
  logic [SW-1:0]             set_c;
  logic [AW-1:0]             tag_c;
  logic [WAYS-1:0]           inuse, match, cand;
  logic                      hit_c;
  logic [WIX-1:0]            x_c;
  logic [AW-1:0]             vaddr_c;
  logic [WIX-1:0]            y;
  logic [WAYS-1:0]           nv, nd;
  logic [WAYS-1:0][WIX-1:0]  nrk, init_rk;
  logic [WAYS-1:0][AW-1:0]   ntg;
  logic                      we, re;
  logic [SW-1:0]             wa;
  logic [WAYS-1:0]           wv, wd;
  logic [WAYS-1:0][WIX-1:0]  wrk;
  logic [WAYS-1:0][AW-1:0]   wtg;

  // Effective geometry: index bits limited to the sets present, ways clamped.
  always_comb begin
    ib = (index_bits_req > 4'(IBMAX)) ? 4'(IBMAX) : index_bits_req;
    if (ways_req == '0) begin
      ways_eff = 6'd1;
    end else if ({1'b0, ways_req} > 6'(WAYS)) begin
      ways_eff = 6'(WAYS);
    end else begin
      ways_eff = {1'b0, ways_req};
    end
    for (int i = 0; i < WAYS; i++) begin
      inuse[i] = 6'(i) < ways_eff;
    end
  end

  // Address split.
  assign sh    = 5'(block_offset_bits) + 5'(ib);
  assign set_c = SW'((req_addr >> block_offset_bits) & ~({AW{1'b1}} << ib));
  assign tag_c = req_addr >> sh;

  // Tag compare and victim choice: the lowest way in use of the highest rank.
  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      match[i] = inuse[i] && rd_v_r[i] && (rd_tg_r[i] == tag_r);
      cand[i]  = inuse[i];
      for (int j = 0; j < WAYS; j++) begin
        if (inuse[j] && (j < i) && !(rd_rk_r[j] < rd_rk_r[i])) begin
          cand[i] = 1'b0;
        end
        if (inuse[j] && (j > i) && (rd_rk_r[j] > rd_rk_r[i])) begin
          cand[i] = 1'b0;
        end
      end
    end
    hit_c = |match;
    x_c   = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (hit_c ? match[i] : cand[i]) begin
        x_c = WIX'(i);
      end
    end
    vaddr_c = (rd_tg_r[x_c] << sh) | (AW'(set_r) << block_offset_bits);
  end

  // Updated row: fill on a miss, set dirty on a write, move the way to rank zero.
  always_comb begin
    nv  = rd_v_r;
    nd  = rd_d_r;
    ntg = rd_tg_r;
    y   = rd_rk_r[x_r];
    for (int i = 0; i < WAYS; i++) begin
      init_rk[i] = WIX'(i);
      nrk[i]     = rd_rk_r[i];
      if (inuse[i] && (WIX'(i) != x_r) && (rd_rk_r[i] < y)) begin
        nrk[i] = rd_rk_r[i] + 1'b1;
      end
    end
    nrk[x_r] = '0;
    if (hit_r) begin
      nd[x_r] = rd_d_r[x_r] | wr_r;
    end else begin
      nv[x_r]  = 1'b1;
      nd[x_r]  = wr_r;
      ntg[x_r] = tag_r;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tlc_pkg::LV_CLEAR: begin
        if (clr_r == SW'(SETS - 1)) begin
          state_nxt = tlc_pkg::LV_IDLE;
        end
      end
      tlc_pkg::LV_IDLE: begin
        if (req) begin
          state_nxt = tlc_pkg::LV_EVAL;
        end
      end
      tlc_pkg::LV_EVAL:  state_nxt = tlc_pkg::LV_WRITE;
      tlc_pkg::LV_WRITE: state_nxt = tlc_pkg::LV_IDLE;
      default:           state_nxt = tlc_pkg::LV_CLEAR;
    endcase
  end

  // State outputs and memory port control.
  always_comb begin
    ready = 1'b0;
    done  = 1'b0;
    we    = 1'b0;
    re    = 1'b0;
    wa    = set_r;
    wv    = nv;
    wd    = nd;
    wrk   = nrk;
    wtg   = ntg;
    unique case (state_r)
      tlc_pkg::LV_CLEAR: begin
        we  = 1'b1;
        wa  = clr_r;
        wv  = '0;
        wd  = '0;
        wrk = init_rk;
      end
      tlc_pkg::LV_IDLE: begin
        ready = 1'b1;
        re    = req;
      end
      tlc_pkg::LV_EVAL: begin
      end
      tlc_pkg::LV_WRITE: begin
        done = 1'b1;
        we   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign res         = '{hit: hit_r, victim_dirty: vd_r};
  assign victim_addr = vaddr_r;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tlc_pkg::LV_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == tlc_pkg::LV_CLEAR) begin
        clr_r <= clr_r + 1'b1;
      end
    end
  end

  // Access registers.
  always_ff @(posedge clk) begin
    if (re) begin
      set_r <= set_c;
      tag_r <= tag_c;
      wr_r  <= req_write;
    end
    if (state_r == tlc_pkg::LV_EVAL) begin
      hit_r   <= hit_c;
      x_r     <= x_c;
      vd_r    <= !hit_c && rd_v_r[x_c] && rd_d_r[x_c];
      vaddr_r <= vaddr_c;
    end
  end

  // Set memory with registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_v[wa]  <= wv;
      mem_d[wa]  <= wd;
      mem_rk[wa] <= wrk;
      mem_tg[wa] <= wtg;
    end
    if (re) begin
      rd_v_r  <= mem_v[set_c];
      rd_d_r  <= mem_d[set_c];
      rd_rk_r <= mem_rk[set_c];
      rd_tg_r <= mem_tg[set_c];
    end
  end

endmodule

@@ hw/rtl/tlc_back.sv @@
`timescale 1ns / 1ps

module tlc_back #(
  parameter int L1_SETS    = tlc_pkg::L1_SETS_DEF,
  parameter int L1_WAYS    = tlc_pkg::L1_WAYS_DEF,
  parameter int L2_SETS    = tlc_pkg::L2_SETS_DEF,
  parameter int L2_WAYS    = tlc_pkg::L2_WAYS_DEF,
  parameter int ADDR_WIDTH = tlc_pkg::ADDR_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tlc_pkg::cfg_t         cfg,
  input  logic                  head_valid,
  input  logic                  head_func,
  input  logic [ADDR_WIDTH-1:0] head_addr,
  output logic                  pop,
  output logic                  init_done,
  tlc_out_if.source             out_ch
);

  tlc_pkg::bk_state_t    state_r, state_nxt;
  tlc_pkg::result_t      acc_r, acc_nxt;
  tlc_pkg::result_t      out_r;
  logic                  out_valid_r;
  logic                  init_done_r;
  logic [ADDR_WIDTH-1:0] addr_r;

  logic                  l1_ready, l1_done, l2_ready, l2_done;
  tlc_pkg::lv_res_t      l1_res, l2_res;
  logic [ADDR_WIDTH-1:0] l1_vaddr, l2_vaddr;
  logic                  l2_req, l2_write;
  logic [ADDR_WIDTH-1:0] l2_addr;
  logic                  l1_miss_l2, load_out;

  // Both clearing passes have finished once init_done_r is set.
  assign init_done  = init_done_r;
  assign l1_miss_l2 = l1_done && !l1_res.hit && cfg.l2_enable;

  tlc_level #(
    .SETS       (L1_SETS),
    .WAYS       (L1_WAYS),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_l1 (
    .clk               (clk),
    .rst_n             (rst_n),
    .block_offset_bits (cfg.block_offset_bits),
    .index_bits_req    (cfg.l1_index_bits),
    .ways_req          ({1'b0, cfg.l1_ways}),
    .req               (pop),
    .req_write         (head_func),
    .req_addr          (head_addr),
    .ready             (l1_ready),
    .done              (l1_done),
    .res               (l1_res),
    .victim_addr       (l1_vaddr)
  );

  tlc_level #(
    .SETS       (L2_SETS),
    .WAYS       (L2_WAYS),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_l2 (
    .clk               (clk),
    .rst_n             (rst_n),
    .block_offset_bits (cfg.block_offset_bits),
    .index_bits_req    (cfg.l2_index_bits),
    .ways_req          (cfg.l2_ways),
    .req               (l2_req),
    .req_write         (l2_write),
    .req_addr          (l2_addr),
    .ready             (l2_ready),
    .done              (l2_done),
    .res               (l2_res),
    .victim_addr       (l2_vaddr)
  );

  // Next state of the access sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tlc_pkg::BK_IDLE: begin
        if (pop) begin
          state_nxt = tlc_pkg::BK_L1;
        end
      end
      tlc_pkg::BK_L1: begin
        if (l1_miss_l2 && l1_res.victim_dirty) begin
          state_nxt = tlc_pkg::BK_L2W;
        end else if (l1_miss_l2) begin
          state_nxt = tlc_pkg::BK_L2R;
        end else if (l1_done) begin
          state_nxt = tlc_pkg::BK_DONE;
        end
      end
      tlc_pkg::BK_L2W: begin
        if (l2_done) begin
          state_nxt = tlc_pkg::BK_L2R;
        end
      end
      tlc_pkg::BK_L2R: begin
        if (l2_done) begin
          state_nxt = tlc_pkg::BK_DONE;
        end
      end
      tlc_pkg::BK_DONE: begin
        if (load_out) begin
          state_nxt = tlc_pkg::BK_IDLE;
        end
      end
      default: state_nxt = tlc_pkg::BK_IDLE;
    endcase
  end

  // Sequencer outputs: unit requests and result loading.
  always_comb begin
    pop      = 1'b0;
    l2_req   = 1'b0;
    l2_write = 1'b0;
    l2_addr  = addr_r;
    load_out = 1'b0;
    unique case (state_r)
      tlc_pkg::BK_IDLE: begin
        pop = head_valid && init_done;
      end
      tlc_pkg::BK_L1: begin
        l2_req = l1_miss_l2;
        if (l1_res.victim_dirty) begin
          l2_write = 1'b1;
          l2_addr  = l1_vaddr;
        end
      end
      tlc_pkg::BK_L2W: begin
      end
      tlc_pkg::BK_L2R: begin
        // After a writeback L2 is idle on entry and takes the read here; a read
        // issued from BK_L1 keeps L2 busy until it is done.
        l2_req = l2_ready;
      end
      tlc_pkg::BK_DONE: begin
        load_out = !out_valid_r || out_ch.ready;
      end
      default: begin
      end
    endcase
  end

  // Result accumulation over the accesses of one item.
  always_comb begin
    acc_nxt = acc_r;
    if (pop) begin
      acc_nxt = '0;
    end
    if (l1_done) begin
      acc_nxt.l1_hit       = l1_res.hit;
      acc_nxt.l1_writeback = l1_res.victim_dirty;
      if (!l1_res.hit && !cfg.l2_enable) begin
        acc_nxt.mem_transfers = l1_res.victim_dirty ? 3'd2 : 3'd1;
      end
    end
    if (l2_done) begin
      if (state_r == tlc_pkg::BK_L2W) begin
        acc_nxt.l2_write_issued = 1'b1;
        acc_nxt.l2_write_hit    = l2_res.hit;
      end else begin
        acc_nxt.l2_read_issued = 1'b1;
        acc_nxt.l2_read_hit    = l2_res.hit;
      end
      acc_nxt.l2_writebacks = acc_r.l2_writebacks + 2'(l2_res.victim_dirty);
      acc_nxt.mem_transfers = acc_r.mem_transfers + 3'(!l2_res.hit)
                              + 3'(l2_res.victim_dirty);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tlc_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
      init_done_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (l1_ready && l2_ready) begin
        init_done_r <= 1'b1;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (pop) begin
      addr_r <= head_addr;
    end
    if (load_out) begin
      out_r <= acc_r;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.l1_hit          = out_r.l1_hit;
  assign out_ch.l1_writeback    = out_r.l1_writeback;
  assign out_ch.l2_read_issued  = out_r.l2_read_issued;
  assign out_ch.l2_read_hit     = out_r.l2_read_hit;
  assign out_ch.l2_write_issued = out_r.l2_write_issued;
  assign out_ch.l2_write_hit    = out_r.l2_write_hit;
  assign out_ch.l2_writebacks   = out_r.l2_writebacks;
  assign out_ch.mem_transfers   = out_r.mem_transfers;

endmodule

@@ hw/rtl/two_level_writeback_lru_cache.sv @@
`timescale 1ns / 1ps

// Channel  Dir  Payload                                            Accepted when
// in_ch    in   func, address                                      valid && ready
// out_ch   out  l1_hit .. l2_write_hit, l2_writebacks, mem_transfers valid && ready
// cfg_ch   in   index, data                                        valid && ready
//
// An item popped from the queue goes through an L1 access; on an L1 miss with L2 enabled
// a dirty L1 victim is first written to L2, and then L2 is read. The result is then
// loaded into the output register and shows in the cycle after the load; each level is
// a read-modify-write of one set row through its set memory. After reset a clearing
// pass initializes the set memories; no item is accepted meanwhile. A two-entry
// queue keeps taking items while the back is busy, and one result waits in the output
// register while the next item is worked on; the back stalls before loading a second.
module two_level_writeback_lru_cache #(
  parameter int L1_SETS    = tlc_pkg::L1_SETS_DEF,
  parameter int L1_WAYS    = tlc_pkg::L1_WAYS_DEF,
  parameter int L2_SETS    = tlc_pkg::L2_SETS_DEF,
  parameter int L2_WAYS    = tlc_pkg::L2_WAYS_DEF,
  parameter int ADDR_WIDTH = tlc_pkg::ADDR_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  tlc_in_if.sink     in_ch,
  tlc_out_if.source  out_ch,
  tlc_cfg_if.sink    cfg_ch
);

  tlc_pkg::cfg_t         cfg_r;
  logic                  init_done, pop, head_valid, head_func;
  logic [ADDR_WIDTH-1:0] head_addr;

  // Configuration registers; writes are always taken.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.block_offset_bits <= tlc_pkg::RST_BLOCK_OFFSET;
      cfg_r.l1_index_bits     <= tlc_pkg::RST_L1_INDEX;
      cfg_r.l1_ways           <= tlc_pkg::RST_L1_WAYS;
      cfg_r.l2_enable         <= tlc_pkg::RST_L2_ENABLE;
      cfg_r.l2_index_bits     <= tlc_pkg::RST_L2_INDEX;
      cfg_r.l2_ways           <= tlc_pkg::RST_L2_WAYS;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        tlc_pkg::CFG_BLOCK_OFFSET: cfg_r.block_offset_bits <= cfg_ch.data[2:0];
        tlc_pkg::CFG_L1_INDEX:     cfg_r.l1_index_bits     <= cfg_ch.data[3:0];
        tlc_pkg::CFG_L1_WAYS:      cfg_r.l1_ways           <= cfg_ch.data[3:0];
        tlc_pkg::CFG_L2_ENABLE:    cfg_r.l2_enable         <= cfg_ch.data[0];
        tlc_pkg::CFG_L2_INDEX:     cfg_r.l2_index_bits     <= cfg_ch.data[3:0];
        tlc_pkg::CFG_L2_WAYS:      cfg_r.l2_ways           <= cfg_ch.data[4:0];
        default: begin
        end
      endcase
    end
  end

  tlc_front #(
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .init_done  (init_done),
    .pop        (pop),
    .head_valid (head_valid),
    .head_func  (head_func),
    .head_addr  (head_addr)
  );

  tlc_back #(
    .L1_SETS    (L1_SETS),
    .L1_WAYS    (L1_WAYS),
    .L2_SETS    (L2_SETS),
    .L2_WAYS    (L2_WAYS),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head_valid (head_valid),
    .head_func  (head_func),
    .head_addr  (head_addr),
    .pop        (pop),
    .init_done  (init_done),
    .out_ch     (out_ch)
  );

  // An L2 hit is only reported for an L2 access that was issued.
  a_read_hit_issued: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.l2_read_hit |-> out_ch.l2_read_issued)
    else $error("L2 read hit without an L2 read");

  a_write_hit_issued: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.l2_write_hit |-> out_ch.l2_write_issued)
    else $error("L2 write hit without an L2 write");

  // An L1 hit causes no traffic below L1.
  a_l1_hit_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.l1_hit |-> !out_ch.l2_read_issued && !out_ch.l1_writeback
                                      && (out_ch.mem_transfers == 3'd0))
    else $error("L1 hit with lower level traffic");

  // An L2 write is only issued for a dirty L1 victim.
  a_write_needs_victim: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.l2_write_issued |-> out_ch.l1_writeback && out_ch.l2_read_issued)
    else $error("L2 write without a dirty L1 victim");

endmodule
